/* hw/rtl/rcof_pkg.sv */
package rcof_pkg;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  localparam int unsigned PKT_BYTES   = 50;
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned FRAME_BITS  = 56;
  localparam int unsigned MAN_BITS    = 2 * FRAME_BITS;
  // packet bytes 35..49 carry the coded frame
  localparam int unsigned TAIL_BYTES  = 15;
  localparam int unsigned TAIL_BITS   = 8 * TAIL_BYTES;
  // frame starts at packet bit 281, i.e. bit 1 (MSB first) of byte 35
  localparam int unsigned TAIL_LEAD   = 1;

  localparam logic [5:0] IDX_WAKE_END  = 6'd16;
  localparam logic [5:0] IDX_QUIET_END = 6'd31;
  localparam logic [5:0] IDX_SYNC0     = 6'd32;
  localparam logic [5:0] IDX_SYNC1     = 6'd33;
  localparam logic [5:0] IDX_SYNC2     = 6'd34;
  localparam logic [5:0] IDX_TAIL0     = 6'd35;
  localparam logic [5:0] IDX_LAST      = 6'd49;

  localparam logic [7:0] CODE_OFFSET = 8'h32;
  localparam logic [7:0] BYTE_WAKE   = 8'hff;
  localparam logic [7:0] BYTE_QUIET  = 8'h00;
  localparam logic [7:0] BYTE_SYNC_A = 8'hf0;
  localparam logic [7:0] BYTE_SYNC_B = 8'hff;

  // Seven-byte frame, byte 0 in the top bits, checksum and chaining applied.
  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic [3:0]        cmd,
    input logic [CODE_W-1:0] code,
    input logic [ADDR_W-1:0] addr
  );
    logic [7:0] b [7];
    logic [3:0] ck;
    logic [FRAME_BITS-1:0] fr;
    b[0] = code[7:0] + CODE_OFFSET;
    b[1] = {cmd, 4'h0};
    b[2] = code[15:8];
    b[3] = code[7:0];
    b[4] = addr[23:16];
    b[5] = addr[15:8];
    b[6] = addr[7:0];
    ck = 4'h0;
    for (int i = 0; i < 7; i++) begin
      ck = ck ^ b[i][3:0] ^ b[i][7:4];
    end
    b[1][3:0] = ck;
    for (int i = 1; i < 7; i++) begin
      b[i] = b[i] ^ b[i-1];
    end
    for (int i = 0; i < 7; i++) begin
      fr[FRAME_BITS-1-8*i -: 8] = b[i];
    end
    return fr;
  endfunction

endpackage

/* hw/rtl/rolling_code_ook_frame_encoder.sv */
// Channel | Ports                                         | Dir | Notes
// in      | in_valid in_ready in_opcode in_command        | in  | send or load item
//         | in_load_value                                 |     |
// out     | out_valid out_ready out_packet_byte           | out | one packet byte per item
//         | out_byte_index out_last                       |     |
// cfg     | cfg_wr_en cfg_wr_data                         | in  | remote address, no wait
//
// A send item yields 50 output items, one per cycle when out_ready stays high;
// the emitter count steps through them.
// A load item yields nothing.
// in_ready drops while the emitter holds a frame and rises again in the cycle
// the last byte leaves, so the next item is taken with no gap.
// rst_n (synchronous) clears the rolling code, address, and all control state.
module rolling_code_ook_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [3:0]  in_command,
  input  logic [15:0] in_load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_packet_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  import rcof_pkg::*;

  // architectural state
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic [ADDR_W-1:0]     addr_r;

  // frame held for the emitter, Manchester coded
  logic [MAN_BITS-1:0]   man_r, man_nxt;
  logic                  active_r, active_nxt;
  logic [5:0]            cnt_r, cnt_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic [5:0]            out_idx_r, out_idx_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_fire;
  logic                  emit_go;
  logic                  emit_done;
  logic [FRAME_BITS-1:0] frame;
  logic [MAN_BITS-1:0]   man_new;
  logic [TAIL_BITS-1:0]  tail;
  logic [3:0]            tail_idx;
  logic [7:0]            cur_byte;

  // emitter advances when the output register is empty or being drained
  assign emit_go   = active_r && (!out_valid_r || out_ready);
  assign emit_done = emit_go && (cnt_r == IDX_LAST);
  assign in_ready  = !active_r || emit_done;
  assign in_fire   = in_valid && in_ready;

  // frame is built from the code as it stands when the send is taken
  assign frame = build_frame(in_command, code_r, addr_r);

  // each frame bit becomes (inverse, bit), MSB first
  always_comb begin
    for (int k = 0; k < FRAME_BITS; k++) begin
      man_new[MAN_BITS-1-2*k] = ~frame[FRAME_BITS-1-k];
      man_new[MAN_BITS-2-2*k] =  frame[FRAME_BITS-1-k];
    end
  end

  // bytes 35..49: one lead zero, coded frame, zero fill
  assign tail     = {{TAIL_LEAD{1'b0}}, man_r, {(TAIL_BITS-TAIL_LEAD-MAN_BITS){1'b0}}};
  // offset into the tail; only the low nibble matters for 15 bytes
  assign tail_idx = cnt_r[3:0] - IDX_TAIL0[3:0];

  always_comb begin
    case (cnt_r) inside
      [6'd0:IDX_WAKE_END]:        cur_byte = BYTE_WAKE;
      [6'd17:IDX_QUIET_END]:      cur_byte = BYTE_QUIET;
      IDX_SYNC0, IDX_SYNC1:       cur_byte = BYTE_SYNC_A;
      IDX_SYNC2:                  cur_byte = BYTE_SYNC_B;
      [IDX_TAIL0:IDX_LAST]:       cur_byte = tail[TAIL_BITS-1-8*tail_idx -: 8];
      default:                    cur_byte = BYTE_QUIET;
    endcase
  end

  always_comb begin
    code_nxt      = code_r;
    man_nxt       = man_r;
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_idx_nxt   = cnt_r;
      out_last_nxt  = (cnt_r == IDX_LAST);
      cnt_nxt       = cnt_r + 6'd1;
      if (cnt_r == IDX_LAST) begin
        active_nxt = 1'b0;
      end
    end

    if (in_fire) begin
      if (opcode_t'(in_opcode) == OP_LOAD) begin
        code_nxt = in_load_value;
      end else begin
        man_nxt    = man_new;
        active_nxt = 1'b1;
        cnt_nxt    = 6'd0;
        code_nxt   = code_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r      <= '0;
      addr_r      <= '0;
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      code_r      <= code_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        addr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    man_r      <= man_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packet_byte = out_byte_r;
  assign out_byte_index  = out_idx_r;
  assign out_last        = out_last_r;

endmodule

/* dv/tb_top.sv */
module tb_top;
  import rcof_pkg::*;

  // Packet geometry, as laid out on air.
  localparam int unsigned PKT_W       = 8 * PKT_BYTES;
  localparam int unsigned WAKE_BYTES  = 17;
  localparam int unsigned FRAME_START = 281;
  localparam int unsigned CODE_ADD    = 8'h32;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One packet byte as the receiver should see it.
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] idx;
    logic       last;
  } pkt_byte_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        in_opcode     = OP_SEND;
  logic [3:0]  in_command    = 4'h0;
  logic [15:0] in_load_value = 16'h0000;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [7:0]  out_packet_byte;
  logic [5:0]  out_byte_index;
  logic        out_last;
  logic        cfg_wr_en     = 1'b0;
  logic [23:0] cfg_wr_data   = 24'h000000;

  // Shadow of the block state, advanced on every accepted item.
  logic [15:0] code_now = 16'h0000;
  logic [23:0] addr_now = 24'h000000;

  pkt_byte_t   pkt_q[$];        // packet bytes still owed by the block
  bit          steady = 1'b0;   // no idling on either side while set
  int unsigned errors      = 0;
  int unsigned sends_sent  = 0;
  int unsigned loads_sent  = 0;
  int unsigned bytes_seen  = 0;
  int unsigned addr_writes = 0;
  int unsigned cycle_count = 0;

  rolling_code_ook_frame_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_command     (in_command),
    .in_load_value  (in_load_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packet_byte(out_packet_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Full 50-byte OOK packet for one send, byte 0 in the top bits.
  function automatic logic [PKT_W-1:0] ook_packet(
    input logic [3:0]  cmd,
    input logic [15:0] code,
    input logic [23:0] addr
  );
    logic [7:0]       fb [7];
    logic [7:0]       sum;
    logic [PKT_W-1:0] pkt;
    int unsigned      pos;
    fb[0] = code[7:0] + CODE_ADD[7:0];
    fb[1] = {cmd, 4'h0};
    fb[2] = code[15:8];
    fb[3] = code[7:0];
    fb[4] = addr[23:16];
    fb[5] = addr[15:8];
    fb[6] = addr[7:0];
    // checksum folds each byte's high nibble onto its low nibble, ck slot still zero
    sum = 8'h00;
    for (int i = 0; i < 7; i++) begin
      sum = sum ^ fb[i] ^ (fb[i] >> 4);
    end
    fb[1][3:0] = sum[3:0];
    // chain: each byte XOR the already-chained byte before it
    for (int i = 1; i < 7; i++) begin
      fb[i] = fb[i] ^ fb[i-1];
    end
    pkt = '0;
    for (int i = 0; i < WAKE_BYTES; i++) begin
      pkt[PKT_W-1-8*i -: 8] = 8'hff;
    end
    pkt[PKT_W-1-8*32 -: 8] = 8'hf0;
    pkt[PKT_W-1-8*33 -: 8] = 8'hf0;
    pkt[PKT_W-1-8*34 -: 8] = 8'hff;
    // Manchester: inverse first, then the bit, so a one goes out as 01
    pos = FRAME_START;
    for (int i = 0; i < 7; i++) begin
      for (int b = 7; b >= 0; b--) begin
        pkt[PKT_W-1-pos] = ~fb[i][b];
        pkt[PKT_W-2-pos] = fb[i][b];
        pos = pos + 2;
      end
    end
    return pkt;
  endfunction

  // Offer one item; returns at the clock edge that takes it, valid left high
  // so a following item goes out with no bubble.
  task automatic send_item(input opcode_t op, input logic [3:0] cmd,
                           input logic [15:0] value);
    int unsigned      gap;
    logic [PKT_W-1:0] pkt;
    pkt_byte_t        pb;
    gap = 0;
    if (!steady && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_command    <= cmd;
    in_load_value <= value;
    // handshake is settled by the falling edge; the next rising edge takes it
    do @(negedge clk); while (in_ready !== 1'b1);
    if (op == OP_LOAD) begin
      code_now = value;
      loads_sent++;
    end else begin
      pkt = ook_packet(cmd, code_now, addr_now);
      for (int i = 0; i < PKT_BYTES; i++) begin
        pb.data = pkt[PKT_W-1-8*i -: 8];
        pb.idx  = 6'(i);
        pb.last = (i == PKT_BYTES - 1);
        pkt_q.push_back(pb);
      end
      code_now = code_now + 16'd1;
      sends_sent++;
    end
    @(posedge clk);
  endtask

  // Stop offering and hold until every owed packet byte has come out.
  task automatic drain_packets();
    in_valid <= 1'b0;
    while (pkt_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Address write only while idle; a trailing load may still be in flight,
  // so give it a few cycles past the last packet byte.
  task automatic set_address(input logic [23:0] addr);
    drain_packets();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    addr_now = addr;
    addr_writes++;
  endtask

  task automatic test_reset_state();
    // code and address both zero straight out of reset
    send_item(OP_SEND, 4'h0, 16'hffff);
  endtask

  task automatic test_all_commands();
    set_address(24'hffffff);
    steady = 1'b1;
    for (int c = 0; c < 16; c++) begin
      send_item(OP_SEND, 4'(c), 16'($urandom_range(0, 16'hffff)));
    end
    steady = 1'b0;
  endtask

  task automatic test_code_wrap();
    set_address(24'($urandom()));
    // command is a don't-care on a load; low code byte also wraps past +0x32
    send_item(OP_LOAD, 4'hf, 16'hffff);
    send_item(OP_SEND, 4'h5, 16'h0000);
    send_item(OP_SEND, 4'ha, 16'h1234);
  endtask

  task automatic test_random_traffic(input int unsigned n_items,
                                     input logic [23:0] addr);
    int unsigned pick;
    set_address(addr);
    for (int n = 0; n < n_items; n++) begin
      // one full pause partway through, sender waits for the packet to drain
      if (n == n_items / 2) begin
        drain_packets();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_item(OP_SEND, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hffff)));
      end else if (pick < 85) begin
        send_item(OP_LOAD, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hffff)));
      end else begin
        // park the code just below the wrap
        send_item(OP_LOAD, 4'($urandom_range(0, 15)),
                  16'($urandom_range(16'hfff8, 16'hffff)));
      end
    end
  endtask

  // Receiver stalls in bursts of random length while steady is clear.
  initial begin : sink_stall
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each taken packet byte against the oldest owed one.
  initial begin : packet_checker
    pkt_byte_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        bytes_seen++;
        if (pkt_q.size() == 0) begin
          errors++;
          $error("unexpected packet byte %02h at index %0d", out_packet_byte,
                 out_byte_index);
        end else begin
          want = pkt_q.pop_front();
          if (out_packet_byte !== want.data) begin
            errors++;
            $error("packet_byte: expected %02h, got %02h", want.data, out_packet_byte);
          end
          if (out_byte_index !== want.idx) begin
            errors++;
            $error("byte_index: expected %0d, got %0d", want.idx, out_byte_index);
          end
          if (out_last !== want.last) begin
            errors++;
            $error("last: expected %0b, got %0b", want.last, out_last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_seq
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_all_commands();
    test_code_wrap();
    test_random_traffic(75, 24'($urandom()));
    test_random_traffic(75, 24'h000000);
    test_random_traffic(75, 24'($urandom()));
    // closing stretch runs flat out on both sides
    steady = 1'b1;
    test_random_traffic(75, 24'($urandom()));

    drain_packets();
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d sends and %0d code loads over %0d address settings,",
             sends_sent, loads_sent, addr_writes);
    $display("checking %0d packet bytes incl. all commands and code wrap.", bytes_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rcof_pkg.sv
hw/rtl/rolling_code_ook_frame_encoder.sv
dv/tb_top.sv
